// File: rtl/cdq_pkg.sv
// shared constants, codes and types for the circular deque
package cdq_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int DATA_W        = 32;
    localparam int MODE_W        = 3;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 10;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PEEK_BACK  = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // data returned when the deque has nothing to give
    localparam logic signed [DATA_W-1:0] DATA_NONE = -32'sd1;

    // result fields known at accept time; the stored word comes from the registered store read, in the cycle after
    typedef struct packed {
        logic                     use_mem;
        logic signed [DATA_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
    } cdq_res_t;

endpackage

// File: rtl/cdq_ring.sv
// ring store: one write port, one registered read port
module cdq_ring #(
    parameter int DEPTH  = cdq_pkg::DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [ADDR_W-1:0]                 wr_addr,
    input  logic signed [cdq_pkg::DATA_W-1:0] wr_data,
    input  logic                              rd_en,
    input  logic [ADDR_W-1:0]                 rd_addr,
    output logic signed [cdq_pkg::DATA_W-1:0] rd_data
);
    import cdq_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/circular_deque.sv
// circular deque: double-ended queue of signed 32-bit words in a ring store
//
// Input channel s_*: one operation per transfer (s_mode, s_value). Push front,
// push back, pop front, pop back, peek front, peek back. Every transfer gives
// exactly one result on m_*: data, status, count and is_empty.
// Throughput: one operation per cycle while s_ready is high. Pointers and the
// item count update at the input transfer, so back-to-back operations see each
// other with no bubble; the store has one write and one registered read port.
// Holding at most DEPTH-1 items, a push onto a full deque is dropped with
// status full; a pop or peek on an empty deque returns -1 with status empty.
// Stall: a result stage and an output register sit between the channels, so
// one more operation is taken while a result waits; s_ready drops only when
// both are occupied and m_ready is low.
// Reset (aresetn low, synchronous): pointers and count clear, the deque is
// empty, both result stages are emptied. Store contents are not cleared;
// no clearing pass is needed since only held entries are ever read.
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [cdq_pkg::MODE_W-1:0]          s_mode,
    input  logic signed [cdq_pkg::DATA_W-1:0]   s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [cdq_pkg::DATA_W-1:0]   m_data,
    output logic [cdq_pkg::STATUS_W-1:0]        m_status,
    output logic [cdq_pkg::COUNT_W-1:0]         m_count,
    output logic                                m_is_empty
);
    import cdq_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int WIDE_W = PTR_W + COUNT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [PTR_W-1:0] front_reg, front_next;
    logic [PTR_W-1:0] back_reg, back_next;
    logic [PTR_W-1:0] count_reg, count_next;

    logic             p1_valid_reg;
    cdq_res_t         p1_res_reg, p1_res_next;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic [COUNT_W-1:0]       out_count_reg;
    logic                     out_empty_reg;

    logic                     accept;
    logic                     p1_move;
    logic                     is_empty_now;
    logic                     is_full_now;
    logic [PTR_W-1:0]         front_inc;
    logic [PTR_W-1:0]         front_dec;
    logic [PTR_W-1:0]         back_inc;
    logic [PTR_W-1:0]         back_dec;
    logic [WIDE_W-1:0]        count_wide;
    logic                     wr_en;
    logic [PTR_W-1:0]         wr_addr;
    logic                     rd_en;
    logic [PTR_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    logic [PTR_W-1:0]         held_chk;

    // handshake: result stage moves on when the output register frees up
    assign p1_move = p1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !p1_valid_reg || p1_move;
    assign accept  = s_valid && s_ready;

    // ring pointer neighbors
    assign front_inc = (front_reg == PTR_LAST) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? PTR_LAST : front_reg - 1'b1;
    assign back_inc  = (back_reg == PTR_LAST) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? PTR_LAST : back_reg - 1'b1;

    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg == PTR_LAST);

    // operation decode: pointer moves, store access and result fields
    always_comb begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        wr_en       = 1'b0;
        wr_addr     = front_reg;
        rd_en       = 1'b0;
        rd_addr     = back_reg;
        p1_res_next.use_mem = 1'b0;
        p1_res_next.data    = '0;
        p1_res_next.status  = ST_DONE;
        case (s_mode)
            MODE_PUSH_FRONT: begin
                if (is_full_now) begin
                    p1_res_next.status = ST_FULL;
                end else begin
                    wr_en      = accept;
                    wr_addr    = front_reg;
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                if (is_full_now) begin
                    p1_res_next.status = ST_FULL;
                end else begin
                    wr_en      = accept;
                    wr_addr    = back_inc;
                    back_next  = back_inc;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_POP_FRONT, MODE_PEEK_FRONT: begin
                if (is_empty_now) begin
                    p1_res_next.data   = DATA_NONE;
                    p1_res_next.status = ST_EMPTY;
                end else begin
                    rd_en   = accept;
                    rd_addr = front_inc;
                    p1_res_next.use_mem = 1'b1;
                    if (s_mode == MODE_POP_FRONT) begin
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            MODE_POP_BACK, MODE_PEEK_BACK: begin
                if (is_empty_now) begin
                    p1_res_next.data   = DATA_NONE;
                    p1_res_next.status = ST_EMPTY;
                end else begin
                    rd_en   = accept;
                    rd_addr = back_reg;
                    p1_res_next.use_mem = 1'b1;
                    if (s_mode == MODE_POP_BACK) begin
                        back_next  = back_dec;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        count_wide           = WIDE_W'(count_next);
        p1_res_next.count    = count_wide[COUNT_W-1:0];
        p1_res_next.is_empty = (count_next == '0);
    end

    cdq_ring #(
        .DEPTH  (DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // pointer and count state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end else if (accept) begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    // result stage, lines up with the store read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_move) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_res_reg <= p1_res_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p1_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            out_data_reg   <= p1_res_reg.use_mem ? rd_data : p1_res_reg.data;
            out_status_reg <= p1_res_reg.status;
            out_count_reg  <= p1_res_reg.count;
            out_empty_reg  <= p1_res_reg.is_empty;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_data     = out_data_reg;
    assign m_status   = out_status_reg;
    assign m_count    = out_count_reg;
    assign m_is_empty = out_empty_reg;

    // occupancy implied by the pointers, for checking the count register
    assign held_chk = back_reg - front_reg + ((back_reg < front_reg) ? PTR_W'(DEPTH) : '0);

    a_count_matches_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == held_chk)
        else $error("item count disagrees with pointers");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= PTR_LAST)
        else $error("item count beyond capacity");

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> p1_valid_reg)
        else $error("accepted operation lost before result stage");

    a_full_push_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_full_now && (s_mode == MODE_PUSH_FRONT || s_mode == MODE_PUSH_BACK))
        |=> ($stable(front_reg) && $stable(back_reg) && $stable(count_reg)))
        else $error("dropped push changed the deque");

    a_empty_read_no_mem: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_empty_now) |-> !rd_en)
        else $error("store read issued on an empty deque");

endmodule

// File: sim/deque_checker.sv
// result checker for the circular deque: predicts each transfer's result and compares
`timescale 1ns / 100ps

module deque_checker #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [cdq_pkg::MODE_W-1:0]          s_mode,
    input  logic signed [cdq_pkg::DATA_W-1:0]   s_value,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [cdq_pkg::DATA_W-1:0]   m_data,
    input  logic [cdq_pkg::STATUS_W-1:0]        m_status,
    input  logic [cdq_pkg::COUNT_W-1:0]         m_count,
    input  logic                                m_is_empty,
    output int                                  fail_count,
    output int                                  results_owed,
    output int                                  held_items
);
    import cdq_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
    } deque_result_t;

    // private copy of the ring and its two pointers
    logic signed [DATA_W-1:0] ring_copy [DEPTH];
    int                       front_ptr;
    int                       back_ptr;
    deque_result_t            owed_results [$];

    initial begin
        fail_count   = 0;
        results_owed = 0;
        held_items   = 0;
        front_ptr    = 0;
        back_ptr     = 0;
    end

    function automatic int occupancy();
        return (back_ptr + DEPTH - front_ptr) % DEPTH;
    endfunction

    // apply one operation to the private copy and return its result
    function automatic deque_result_t apply_op(input logic [MODE_W-1:0] mode,
                                               input logic signed [DATA_W-1:0] value);
        deque_result_t r;
        bit            was_empty;
        bit            was_full;
        int            n;
        was_empty = (front_ptr == back_ptr);
        was_full  = (occupancy() == DEPTH - 1);
        r.data    = '0;
        r.status  = ST_DONE;
        case (mode)
            MODE_PUSH_FRONT: begin
                if (was_full) begin
                    r.status = ST_FULL;
                end else begin
                    ring_copy[front_ptr] = value;
                    front_ptr = (front_ptr + DEPTH - 1) % DEPTH;
                end
            end
            MODE_PUSH_BACK: begin
                if (was_full) begin
                    r.status = ST_FULL;
                end else begin
                    back_ptr = (back_ptr + 1) % DEPTH;
                    ring_copy[back_ptr] = value;
                end
            end
            MODE_POP_FRONT: begin
                if (was_empty) begin
                    r.data   = DATA_NONE;
                    r.status = ST_EMPTY;
                end else begin
                    front_ptr = (front_ptr + 1) % DEPTH;
                    r.data = ring_copy[front_ptr];
                end
            end
            MODE_POP_BACK: begin
                if (was_empty) begin
                    r.data   = DATA_NONE;
                    r.status = ST_EMPTY;
                end else begin
                    r.data = ring_copy[back_ptr];
                    back_ptr = (back_ptr + DEPTH - 1) % DEPTH;
                end
            end
            MODE_PEEK_FRONT: begin
                if (was_empty) begin
                    r.data   = DATA_NONE;
                    r.status = ST_EMPTY;
                end else begin
                    r.data = ring_copy[(front_ptr + 1) % DEPTH];
                end
            end
            MODE_PEEK_BACK: begin
                if (was_empty) begin
                    r.data   = DATA_NONE;
                    r.status = ST_EMPTY;
                end else begin
                    r.data = ring_copy[back_ptr];
                end
            end
            default: begin
                // spare codes leave everything as it is
            end
        endcase
        n          = occupancy();
        r.count    = n[COUNT_W-1:0];
        r.is_empty = (n == 0);
        return r;
    endfunction

    always @(posedge aclk) begin
        deque_result_t want;
        if (!aresetn) begin
            front_ptr = 0;
            back_ptr  = 0;
            owed_results.delete();
        end else begin
            // result transfer: compare with the oldest prediction
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $error("result transfer with no prediction waiting: data %0d status %0d",
                           m_data, m_status);
                    fail_count++;
                end else begin
                    want = owed_results[0];
                    owed_results.delete(0);
                    if (m_data !== want.data) begin
                        $error("data mismatch: expected %0d, actual %0d", want.data, m_data);
                        fail_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_status);
                        fail_count++;
                    end
                    if (m_count !== want.count) begin
                        $error("count mismatch: expected %0d, actual %0d", want.count, m_count);
                        fail_count++;
                    end
                    if (m_is_empty !== want.is_empty) begin
                        $error("is_empty mismatch: expected %0d, actual %0d",
                               want.is_empty, m_is_empty);
                        fail_count++;
                    end
                end
            end
            // operation transfer: predict its result
            if (s_valid && s_ready) begin
                owed_results.insert(owed_results.size(), apply_op(s_mode, s_value));
            end
        end
        results_owed = owed_results.size();
        held_items   = occupancy();
    end

endmodule

// File: sim/circular_deque_tb.sv
// top of the circular deque testbench: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 100ps

module circular_deque_tb;
    import cdq_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
    localparam int FULL_LEVEL = DEPTH_DEFAULT - 1;
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 8;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [MODE_W-1:0]        s_mode;
    logic signed [DATA_W-1:0] s_value;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_data;
    logic [STATUS_W-1:0]      m_status;
    logic [COUNT_W-1:0]       m_count;
    logic                     m_is_empty;

    int fail_count;
    int results_owed;
    int held_items;
    int snd_idle_pct;
    int rcv_idle_pct;
    int sent_random;
    int quiet_cycles;

    circular_deque dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .m_status   (m_status),
        .m_count    (m_count),
        .m_is_empty (m_is_empty)
    );

    deque_checker chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .m_status     (m_status),
        .m_count      (m_count),
        .m_is_empty   (m_is_empty),
        .fail_count   (fail_count),
        .results_owed (results_owed),
        .held_items   (held_items)
    );

    always #5 aclk = ~aclk;

    // receiver stalls at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // mostly random words, with the extremes mixed in
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return 32'shffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // one transfer on the operation channel, called and returning at a falling edge
    task automatic send_op(input logic [MODE_W-1:0] mode, input logic signed [DATA_W-1:0] value);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // hold off until every predicted result has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (results_owed != 0) @(negedge aclk);
    endtask

    // random operation, switching the stall profile as the run goes on
    task automatic send_random(input logic [MODE_W-1:0] mode);
        if (sent_random == 400) begin
            drain_results();
            snd_idle_pct = 59;
            rcv_idle_pct = 32;
        end else if (sent_random == 800) begin
            drain_results();
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
        end
        send_op(mode, pick_value());
        sent_random++;
    endtask

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_mode       = MODE_PUSH_FRONT;
        s_value      = '0;
        m_ready      = 1'b0;
        quiet_cycles = 0;
        sent_random  = 0;
        snd_idle_pct = 32;
        rcv_idle_pct = 59;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty deque, spare codes, extremes, both ends, pointer wrap
        send_op(MODE_POP_FRONT, pick_value());
        send_op(MODE_POP_BACK, pick_value());
        send_op(MODE_PEEK_FRONT, pick_value());
        send_op(MODE_PEEK_BACK, pick_value());
        send_op(MODE_SPARE_A, pick_value());
        send_op(MODE_SPARE_B, pick_value());
        send_op(MODE_PUSH_FRONT, 32'sh7fff_ffff);
        send_op(MODE_PUSH_BACK, 32'sh8000_0000);
        send_op(MODE_PEEK_FRONT, pick_value());
        send_op(MODE_PEEK_BACK, pick_value());
        send_op(MODE_PUSH_FRONT, 32'shffff_ffff);
        send_op(MODE_PUSH_BACK, 32'sh0000_0000);
        send_op(MODE_SPARE_A, 32'sh7fff_ffff);
        send_op(MODE_POP_BACK, pick_value());
        send_op(MODE_POP_FRONT, pick_value());
        send_op(MODE_PEEK_FRONT, pick_value());
        send_op(MODE_SPARE_B, pick_value());
        send_op(MODE_POP_FRONT, pick_value());
        send_op(MODE_POP_BACK, pick_value());
        send_op(MODE_POP_FRONT, pick_value());
        send_op(MODE_PEEK_BACK, pick_value());

        // random: any code while near empty
        repeat (50) begin
            send_random(MODE_W'($urandom_range(MODE_PUSH_FRONT, MODE_SPARE_B)));
        end

        // random: mostly pushes until the deque is full
        while (held_items != FULL_LEVEL) begin
            if ($urandom_range(99) < 97) begin
                send_random(MODE_W'($urandom_range(MODE_PUSH_FRONT, MODE_PUSH_BACK)));
            end else begin
                send_random(MODE_W'($urandom_range(MODE_POP_FRONT, MODE_SPARE_B)));
            end
        end

        // random: hover at full so pushes get dropped
        repeat (50) begin
            if ($urandom_range(1) == 0) begin
                send_random(MODE_W'($urandom_range(MODE_PUSH_FRONT, MODE_PUSH_BACK)));
            end else begin
                send_random(MODE_W'($urandom_range(MODE_POP_FRONT, MODE_SPARE_B)));
            end
        end

        // wind down and give the verdict
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/cdq_pkg.sv
rtl/cdq_ring.sv
rtl/circular_deque.sv
sim/deque_checker.sv
sim/circular_deque_tb.sv
